[rtl/csdd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity drift detector package
// Shared opcodes, status codes, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package csdd_pkg;

  localparam int FRAC_SHIFT = 20;
  localparam int SIM_ONE    = 16384;
  localparam int SCORE_ONE  = 32768;
  localparam int CDIV_STEPS = 15;
  localparam logic [15:0] THRESH_RESET = 16'd3277;

  typedef enum logic [2:0] {
    OP_REF_ELEM    = 3'd0,
    OP_REF_EMPTY   = 3'd1,
    OP_CUR_ELEM    = 3'd2,
    OP_END_BATCH   = 3'd3,
    OP_CLEAR_REFS  = 3'd4,
    OP_EMPTY_POINT = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_REF      = 2'd1,
    ST_BATCH_EMPTY = 2'd2,
    ST_NO_VALID    = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PT_START,
    S_LEN_RD,
    S_LEN_CHK,
    S_MAC,
    S_MAC_END,
    S_NORM,
    S_SQA_GO,
    S_SQA_WAIT,
    S_SQB_GO,
    S_SQB_WAIT,
    S_MUL,
    S_CDIV_GO,
    S_CDIV_WAIT,
    S_SIM_ADD,
    S_NEXT_REF,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_COMMIT,
    S_END,
    S_AVG_GO,
    S_AVG_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic ref_elem;
    logic ref_empty;
    logic cur_elem;
    logic clear_refs;
    logic empty_point;
    logic pt_init;
    logic ps_clear;
    logic len_rd;
    logic mac_init;
    logic mac_issue;
    logic sqrt_start_a;
    logic sqrt_start_b;
    logic mul;
    logic cdiv_start;
    logic sim_add;
    logic next_ref;
    logic mean_start;
    logic pt_commit;
    logic avg_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic ref_none;
    logic len_ok;
    logic mac_last;
    logic norm_zero;
    logic sqrt_done;
    logic cdiv_done;
    logic div_done;
    logic last_ref;
    logic batch_ok;
    logic out_busy;
  } stat_t;

endpackage

[rtl/csdd_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative square root
// Floor square root, one result bit per cycle, restoring digit recurrence.
// ----------------------------------------------------------------------------
module csdd_sqrt #(
  parameter int IW = 60
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [IW-1:0]   din,
  output logic            done,
  output logic [IW/2-1:0] root
);

  localparam int RW = IW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [IW-1:0] val;
  logic [RW+1:0] rem;
  logic [RW-1:0] res;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;

  assign rem_sh = {rem[RW:0], val[IW-1:IW-2]};
  assign trial  = {1'b0, res, 2'b01};
  assign root   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(RW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val <= din;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      val <= {val[IW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem <= (RW+2)'(rem_sh - trial);
        res <= {res[RW-2:0], 1'b1};
      end else begin
        rem <= (RW+2)'(rem_sh);
        res <= {res[RW-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/csdd_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative rounded divider
// Signed numerator over a positive denominator, rounded to nearest with ties
// away from zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csdd_div #(
  parameter int NW = 32,
  parameter int DW = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic signed [NW-1:0] quot
);

  localparam int MW = ((NW > DW) ? NW : DW) + 1;
  localparam int CW = $clog2(MW + 1);

  logic [MW-1:0] dvd;
  logic [DW-1:0] dvs;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          neg;
  logic [NW-1:0] mag;
  logic [DW:0]   rem_sh;

  assign mag    = num[NW-1] ? NW'(-num) : NW'(num);
  assign rem_sh = {rem, dvd[MW-1]};
  assign quot   = neg ? -$signed(dvd[NW-1:0]) : $signed(dvd[NW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend register shifts the quotient in from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= MW'(mag) + MW'(den >> 1);
      dvs <= den;
      rem <= '0;
      neg <= num[NW-1];
    end else if (busy) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= DW'(rem_sh - {1'b0, dvs});
        dvd <= {dvd[MW-2:0], 1'b1};
      end else begin
        rem <= DW'(rem_sh);
        dvd <= {dvd[MW-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/csdd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drift detector datapath
// Reference and current vector memories, the dot product and norm
// accumulators, square root and division units, batch totals and the output
// register.
// ----------------------------------------------------------------------------
module csdd_dp #(
  parameter int MAX_REFS  = 64,
  parameter int MAX_DIM   = 256,
  parameter int MAX_BATCH = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  csdd_pkg::cmd_t     cmd,
  output csdd_pkg::stat_t    st,
  input  logic signed [15:0] element_value,
  input  logic               last_element,
  input  logic [15:0]        threshold,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [15:0]        out_score,
  output logic               out_drifted,
  output logic signed [15:0] out_avg,
  output logic [16:0]        out_count
);

  import csdd_pkg::*;

  localparam int RCW  = $clog2(MAX_REFS + 1);
  localparam int RIW  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int LW   = $clog2(MAX_DIM + 2);
  localparam int DIW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SD   = MAX_REFS * MAX_DIM;
  localparam int AW   = (SD > 1) ? $clog2(SD) : 1;
  localparam int ABW  = $clog2(SD + 1);
  localparam int VCW  = $clog2(MAX_BATCH + 1);
  localparam int NAW  = 30 + $clog2(MAX_DIM + 1);
  localparam int DTW  = NAW + 1;
  localparam int SIW0 = NAW + FRAC_SHIFT;
  localparam int SIW  = SIW0 + (SIW0 % 2);
  localparam int SQW  = SIW / 2;
  localparam int QW   = 2 * SQW;
  localparam int XW   = NAW + FRAC_SHIFT;
  localparam int CMW  = ((XW > QW + 1) ? XW : QW + 1) + 1;
  localparam int SMW  = RCW + 16;
  localparam int TW   = VCW + 16;
  localparam int DNW  = (TW > SMW) ? TW : SMW;
  localparam int DDW  = (VCW > RCW) ? VCW : RCW;

  // Memories
  logic signed [15:0] ref_mem [SD];
  logic [LW-1:0]      len_mem [MAX_REFS];
  logic signed [15:0] cur_mem [MAX_DIM];

  // Store and batch state
  logic [RCW-1:0]       ref_count;
  logic [LW-1:0]        build_len;
  logic [ABW-1:0]       wr_base;
  logic [LW-1:0]        cur_len;
  logic signed [TW-1:0] total;
  logic [VCW-1:0]       valid_pts;
  logic [VCW-1:0]       batch_pts;

  // Point evaluation
  logic [RCW-1:0]        ref_idx;
  logic [ABW-1:0]        rd_base;
  logic signed [SMW-1:0] sum;
  logic signed [15:0]    ps;
  logic [LW-1:0]         len_q;
  logic [LW-1:0]         mac_i;
  logic                  rd_valid;
  logic signed [15:0]    ref_rd;
  logic signed [15:0]    cur_rd;
  logic signed [DTW-1:0] dot;
  logic [NAW-1:0]        na;
  logic [NAW-1:0]        nb;
  logic [SQW-1:0]        sa;
  logic [SQW-1:0]        sb;
  logic [QW-1:0]         q;
  logic [XW-1:0]         xr;
  logic                  dot_neg;
  logic [QW:0]           cd_rem;
  logic [15:0]           cd_f;
  logic [3:0]            cd_cnt;
  logic                  sq_sel;
  logic                  div_sel;
  logic signed [DNW-1:0] avg_q;

  logic                  ref_full;
  logic                  ref_take;
  logic                  len_wr;
  logic [LW-1:0]         len_wr_val;
  logic [LW-1:0]         bl_inc;
  logic [LW-1:0]         cl_inc;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic                  batch_room;
  logic signed [31:0]    prod_ab;
  logic signed [31:0]    prod_aa;
  logic signed [31:0]    prod_bb;
  logic [DTW-1:0]        dot_mag;
  logic [SIW-1:0]        sq_in;
  logic                  sq_start;
  logic                  sq_done;
  logic [SQW-1:0]        sq_root;
  logic [CMW-1:0]        x_ext;
  logic [CMW-1:0]        q_ext;
  logic [QW:0]           rem_sh;
  logic [15:0]           f_round;
  logic [15:0]           f_sat;
  logic signed [15:0]    sim_val;
  logic                  div_start;
  logic signed [DNW-1:0] div_num;
  logic [DDW-1:0]        div_den;
  logic                  div_done;
  logic signed [DNW-1:0] div_quot;
  logic [1:0]            status_w;
  logic signed [15:0]    avg_c;
  logic signed [17:0]    score_w;
  logic [15:0]           score_c;

  assign ref_full   = (ref_count == RCW'(MAX_REFS));
  assign ref_take   = (cmd.ref_elem || cmd.ref_empty) && !ref_full;
  assign bl_inc     = (build_len <= LW'(MAX_DIM)) ? build_len + LW'(1) : build_len;
  assign cl_inc     = (cur_len <= LW'(MAX_DIM)) ? cur_len + LW'(1) : cur_len;
  assign len_wr     = ref_take && (cmd.ref_empty || last_element);
  assign len_wr_val = cmd.ref_elem ? bl_inc : '0;
  assign wr_addr    = AW'(wr_base + ABW'(build_len));
  assign rd_addr    = AW'(rd_base + ABW'(mac_i));
  assign batch_room = (batch_pts < VCW'(MAX_BATCH));

  always_ff @(posedge clk) begin
    if (cmd.ref_elem && !ref_full && (build_len < LW'(MAX_DIM))) begin
      ref_mem[wr_addr] <= element_value;
    end
    if (cmd.cur_elem && (cur_len < LW'(MAX_DIM))) begin
      cur_mem[cur_len[DIW-1:0]] <= element_value;
    end
    if (len_wr) begin
      len_mem[ref_count[RIW-1:0]] <= len_wr_val;
    end
    if (cmd.mac_issue) begin
      ref_rd <= ref_mem[rd_addr];
      cur_rd <= cur_mem[mac_i[DIW-1:0]];
    end
    if (cmd.len_rd) begin
      len_q <= len_mem[ref_idx[RIW-1:0]];
    end
  end

  // Reference store, current vector and batch bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
      build_len <= '0;
      wr_base   <= '0;
      cur_len   <= '0;
      total     <= '0;
      valid_pts <= '0;
      batch_pts <= '0;
    end else begin
      if (ref_take) begin
        if (len_wr) begin
          ref_count <= ref_count + RCW'(1);
          build_len <= '0;
          wr_base   <= wr_base + ABW'(MAX_DIM);
        end else begin
          build_len <= bl_inc;
        end
      end
      if (cmd.clear_refs) begin
        ref_count <= '0;
        build_len <= '0;
        wr_base   <= '0;
      end
      if (cmd.cur_elem) begin
        cur_len <= cl_inc;
      end
      if (cmd.empty_point) begin
        cur_len <= '0;
        if (batch_room) begin
          batch_pts <= batch_pts + VCW'(1);
        end
      end
      if (cmd.pt_commit) begin
        cur_len <= '0;
        if (batch_room) begin
          total     <= total + TW'(ps);
          valid_pts <= valid_pts + VCW'(1);
          batch_pts <= batch_pts + VCW'(1);
        end
      end
      if (cmd.out_load) begin
        cur_len   <= '0;
        total     <= '0;
        valid_pts <= '0;
        batch_pts <= '0;
      end
    end
  end

  // Dot product and norms
  assign prod_ab = cur_rd * ref_rd;
  assign prod_aa = cur_rd * cur_rd;
  assign prod_bb = ref_rd * ref_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.mac_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_init) begin
      ref_idx <= '0;
      rd_base <= '0;
      sum     <= '0;
    end else if (cmd.next_ref) begin
      ref_idx <= ref_idx + RCW'(1);
      rd_base <= rd_base + ABW'(MAX_DIM);
    end else if (cmd.sim_add) begin
      sum <= sum + SMW'(sim_val);
    end
    if (cmd.mac_init) begin
      mac_i <= '0;
      dot   <= '0;
      na    <= '0;
      nb    <= '0;
    end else begin
      if (cmd.mac_issue) begin
        mac_i <= mac_i + LW'(1);
      end
      if (rd_valid) begin
        dot <= dot + DTW'(prod_ab);
        na  <= na + NAW'($unsigned(prod_aa));
        nb  <= nb + NAW'($unsigned(prod_bb));
      end
    end
  end

  // Norm square roots share one unit.
  assign sq_start = cmd.sqrt_start_a || cmd.sqrt_start_b;
  assign sq_in    = SIW'({cmd.sqrt_start_b ? nb : na, {FRAC_SHIFT{1'b0}}});

  csdd_sqrt #(.IW(SIW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .din   (sq_in),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (sq_start) begin
      sq_sel <= cmd.sqrt_start_b;
    end
    if (sq_done) begin
      if (sq_sel) begin
        sb <= sq_root;
      end else begin
        sa <= sq_root;
      end
    end
  end

  // Cosine quotient: |dot| * 2^20 over the norm product, 15 fraction bits.
  assign dot_mag = dot[DTW-1] ? DTW'(-dot) : DTW'(dot);
  assign x_ext   = CMW'(xr);
  assign q_ext   = CMW'(q);
  assign rem_sh  = {cd_rem[QW-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cd_cnt <= '0;
    end else if (cmd.cdiv_start) begin
      cd_cnt <= (x_ext >= (q_ext << 1)) ? 4'd0 : 4'(CDIV_STEPS);
    end else if (cd_cnt != 4'd0) begin
      cd_cnt <= cd_cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      q       <= QW'(sa * sb);
      xr      <= {dot_mag[NAW-1:0], {FRAC_SHIFT{1'b0}}};
      dot_neg <= dot[DTW-1];
    end
    if (cmd.cdiv_start) begin
      if (x_ext >= (q_ext << 1)) begin
        cd_f <= 16'(SCORE_ONE);
      end else if (x_ext >= q_ext) begin
        cd_f   <= 16'd1;
        cd_rem <= (QW+1)'(x_ext - q_ext);
      end else begin
        cd_f   <= 16'd0;
        cd_rem <= (QW+1)'(x_ext);
      end
    end else if (cd_cnt != 4'd0) begin
      if (rem_sh >= {1'b0, q}) begin
        cd_rem <= rem_sh - {1'b0, q};
        cd_f   <= {cd_f[14:0], 1'b1};
      end else begin
        cd_rem <= rem_sh;
        cd_f   <= {cd_f[14:0], 1'b0};
      end
    end
  end

  assign f_round = 16'(({1'b0, cd_f} + 17'd1) >> 1);
  assign f_sat   = (f_round > 16'(SIM_ONE)) ? 16'(SIM_ONE) : f_round;
  assign sim_val = dot_neg ? -$signed(f_sat) : $signed(f_sat);

  // Point mean and batch average share the rounded divider.
  assign div_start = cmd.mean_start || cmd.avg_start;
  assign div_num   = cmd.avg_start ? DNW'(total) : DNW'(sum);
  assign div_den   = cmd.avg_start ? DDW'(valid_pts) : DDW'(ref_count);

  csdd_div #(.NW(DNW), .DW(DDW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_sel <= cmd.avg_start;
    end
    if (cmd.ps_clear) begin
      ps <= '0;
    end else if (div_done && !div_sel) begin
      ps <= 16'(div_quot);
    end
    if (div_done && div_sel) begin
      avg_q <= div_quot;
    end
  end

  // Batch result
  always_comb begin
    if (ref_count == '0) begin
      status_w = ST_NO_REF;
    end else if (batch_pts == '0) begin
      status_w = ST_BATCH_EMPTY;
    end else if (valid_pts == '0) begin
      status_w = ST_NO_VALID;
    end else begin
      status_w = ST_OK;
    end
    if (avg_q > DNW'(SIM_ONE)) begin
      avg_c = 16'(SIM_ONE);
    end else if (avg_q < -DNW'(SIM_ONE)) begin
      avg_c = -16'(SIM_ONE);
    end else begin
      avg_c = 16'(avg_q);
    end
    score_w = 18'(SCORE_ONE) - (18'(avg_c) <<< 1);
    if (score_w < 18'sd0) begin
      score_c = '0;
    end else if (score_w > 18'(SCORE_ONE)) begin
      score_c = 16'(SCORE_ONE);
    end else begin
      score_c = score_w[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= status_w;
      if (status_w == ST_OK) begin
        out_score   <= score_c;
        out_drifted <= (score_c > threshold);
        out_avg     <= avg_c;
        out_count   <= 17'(valid_pts);
      end else begin
        out_score   <= '0;
        out_drifted <= 1'b0;
        out_avg     <= '0;
        out_count   <= '0;
      end
    end
  end

  assign st.ref_none  = (ref_count == '0);
  assign st.len_ok    = (len_q == cur_len) && (len_q != '0) && (len_q <= LW'(MAX_DIM));
  assign st.mac_last  = ((mac_i + LW'(1)) == len_q);
  assign st.norm_zero = (na == '0) || (nb == '0);
  assign st.sqrt_done = sq_done;
  assign st.cdiv_done = (cd_cnt == 4'd0);
  assign st.div_done  = div_done;
  assign st.last_ref  = ((ref_idx + RCW'(1)) == ref_count);
  assign st.batch_ok  = (ref_count != '0) && (valid_pts != '0);
  assign st.out_busy  = out_valid && !out_ready;

endmodule

[rtl/csdd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drift detector controller
// Decodes accepted words and sequences the per-reference similarity loop,
// the point mean, the batch average and the result hand-off.
// ----------------------------------------------------------------------------
module csdd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2:0]      opcode,
  input  logic            last,
  output logic            in_ready,
  output csdd_pkg::cmd_t  cmd,
  input  csdd_pkg::stat_t st
);

  import csdd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (opcode)
            OP_REF_ELEM:    cmd.ref_elem = 1'b1;
            OP_REF_EMPTY:   cmd.ref_empty = 1'b1;
            OP_CUR_ELEM: begin
              cmd.cur_elem = 1'b1;
              if (last) begin
                state_next = S_PT_START;
              end
            end
            OP_END_BATCH:   state_next = S_END;
            OP_CLEAR_REFS:  cmd.clear_refs = 1'b1;
            OP_EMPTY_POINT: cmd.empty_point = 1'b1;
            default: ;
          endcase
        end
      end
      S_PT_START: begin
        if (st.ref_none) begin
          cmd.ps_clear = 1'b1;
          state_next   = S_COMMIT;
        end else begin
          cmd.pt_init = 1'b1;
          state_next  = S_LEN_RD;
        end
      end
      S_LEN_RD: begin
        cmd.len_rd = 1'b1;
        state_next = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        // A length mismatch or an empty vector adds nothing to the sum.
        if (st.len_ok) begin
          cmd.mac_init = 1'b1;
          state_next   = S_MAC;
        end else begin
          state_next = S_NEXT_REF;
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (st.mac_last) begin
          state_next = S_MAC_END;
        end
      end
      S_MAC_END: state_next = S_NORM;
      S_NORM: state_next = st.norm_zero ? S_NEXT_REF : S_SQA_GO;
      S_SQA_GO: begin
        cmd.sqrt_start_a = 1'b1;
        state_next       = S_SQA_WAIT;
      end
      S_SQA_WAIT: begin
        if (st.sqrt_done) begin
          state_next = S_SQB_GO;
        end
      end
      S_SQB_GO: begin
        cmd.sqrt_start_b = 1'b1;
        state_next       = S_SQB_WAIT;
      end
      S_SQB_WAIT: begin
        if (st.sqrt_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CDIV_GO;
      end
      S_CDIV_GO: begin
        cmd.cdiv_start = 1'b1;
        state_next     = S_CDIV_WAIT;
      end
      S_CDIV_WAIT: begin
        if (st.cdiv_done) begin
          state_next = S_SIM_ADD;
        end
      end
      S_SIM_ADD: begin
        cmd.sim_add = 1'b1;
        state_next  = S_NEXT_REF;
      end
      S_NEXT_REF: begin
        cmd.next_ref = 1'b1;
        state_next   = st.last_ref ? S_MEAN_GO : S_LEN_RD;
      end
      S_MEAN_GO: begin
        cmd.mean_start = 1'b1;
        state_next     = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (st.div_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.pt_commit = 1'b1;
        state_next    = S_IDLE;
      end
      S_END: state_next = st.batch_ok ? S_AVG_GO : S_OUT;
      S_AVG_GO: begin
        cmd.avg_start = 1'b1;
        state_next    = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (st.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/cosine_similarity_drift_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity drift detector
// Stores reference embeddings, averages each current vector's cosine
// similarity over them and reports a drift score at the end of each batch.
// ----------------------------------------------------------------------------
// Reference words, non-final current words and the other control words leave
// the input ready. The last word of a current vector holds the input off while
// each reference of matching length runs the products, the serial square root
// of each norm (SQW is 30 with the defaults) and the cosine division, others
// are skipped; the mean divider follows. End of batch holds the input off too.
// Reset clears the counters and batch totals; the memories are not cleared.
module cosine_similarity_drift_detector #(
  parameter int MAX_REFS  = 64,
  parameter int MAX_DIM   = 256,
  parameter int MAX_BATCH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] element_value
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  input  logic        s_tlast,
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] score, [16] drifted, [32:17] average similarity,
  // [49:33] point count, [55:50] zero
  output logic [55:0] m_tdata,
  output logic [1:0]  m_tuser,   // [1:0] status
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import csdd_pkg::*;

  cmd_t               cmd;
  stat_t              st;
  logic [15:0]        drift_threshold;
  logic               cfg_sel;
  logic [15:0]        res_score;
  logic               res_drifted;
  logic signed [15:0] res_avg;
  logic [16:0]        res_count;
  logic signed [17:0] chk_sum;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == 1'b0);
  assign prdata  = cfg_sel ? {16'd0, drift_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      drift_threshold <= THRESH_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      drift_threshold <= pwdata[15:0];
    end
  end

  csdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .opcode   (s_tuser),
    .last     (s_tlast),
    .in_ready (s_tready),
    .cmd      (cmd),
    .st       (st)
  );

  csdd_dp #(
    .MAX_REFS  (MAX_REFS),
    .MAX_DIM   (MAX_DIM),
    .MAX_BATCH (MAX_BATCH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .element_value ($signed(s_tdata)),
    .last_element  (s_tlast),
    .threshold     (drift_threshold),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .out_status    (m_tuser),
    .out_score     (res_score),
    .out_drifted   (res_drifted),
    .out_avg       (res_avg),
    .out_count     (res_count)
  );

  assign m_tdata = {6'd0, res_count, res_avg, res_drifted, res_score};

  // With a good status the score plus twice the average is one, except that a
  // negative average pins the score at one.
  assign chk_sum = $signed({2'b00, m_tdata[15:0]})
                 + ($signed({{2{m_tdata[32]}}, m_tdata[32:17]}) <<< 1);

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
    else $error("non-ok result carries nonzero fields");

  a_drifted: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[16]) |-> (m_tdata[15:0] > drift_threshold))
    else $error("drifted flag set without score above threshold");

  a_score_avg: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_OK)) |->
      ((chk_sum == 18'sd32768) ||
       (m_tdata[32] && (m_tdata[15:0] == 16'(SCORE_ONE)))))
    else $error("drift score does not match average similarity");

endmodule

[sim/cosine_similarity_drift_detector_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity drift detector testbench
// Drives reference and current embedding words with random gaps, predicts
// each end-of-batch report in a bit-exact model and compares every report
// field by field. Covers the threshold register, a full reference store,
// oversized vectors and a long output stall.
// ----------------------------------------------------------------------------
module cosine_similarity_drift_detector_test;
  import csdd_pkg::*;

  localparam int NREF = 64;
  localparam int NDIM = 256;
  localparam int NBATCH = 65536;
  localparam int DRAIN_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] score;
    logic        drifted;
    logic [15:0] avg;
    logic [16:0] count;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cosine_similarity_drift_detector uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Model state
  logic signed [15:0] ref_mem [NREF][NDIM];
  int                 ref_len [NREF];
  int                 ref_cnt;
  int                 build_len;
  logic signed [15:0] cur_vec [NDIM];
  int                 cur_len;
  longint             sim_total;
  int                 valid_pts;
  int                 batch_pts;
  logic [15:0]        thresh;

  report_t pending_reports [$];
  int      errors = 0;
  int      words_sent = 0;
  int      reports_seen = 0;
  longint  cycles = 0;
  bit      no_idle = 1'b0;
  int      hold_req = 0;
  int      hold_len = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Rounded division, ties away from zero; d is positive.
  function automatic longint round_div(longint n, longint d);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic int cosine_to_ref(int r);
    longint dot, a, b, mag;
    longint unsigned na, nb, q, x, ip, rem, f;
    int len;
    dot = 0; na = 0; nb = 0;
    len = ref_len[r];
    if (len != cur_len || len == 0 || len > NDIM) return 0;
    for (int i = 0; i < len; i++) begin
      a = cur_vec[i];
      b = ref_mem[r][i];
      dot += a * b;
      na += a * a;
      nb += b * b;
    end
    if (na == 0 || nb == 0) return 0;
    q = int_sqrt(na << FRAC_SHIFT) * int_sqrt(nb << FRAC_SHIFT);
    mag = (dot < 0) ? -dot : dot;
    x = mag << FRAC_SHIFT;
    ip = x / q;
    rem = x % q;
    if (ip >= 2) begin
      f = SCORE_ONE;
    end else begin
      f = ip;
      for (int k = 0; k < CDIV_STEPS; k++) begin
        rem <<= 1;
        f <<= 1;
        if (rem >= q) begin
          rem -= q;
          f |= 1;
        end
      end
    end
    f = (f + 1) >> 1;
    if (f > SIM_ONE) f = SIM_ONE;
    return (dot < 0) ? -int'(f) : int'(f);
  endfunction

  task automatic close_point();
    longint sum, ps;
    sum = 0; ps = 0;
    if (ref_cnt != 0) begin
      for (int r = 0; r < ref_cnt; r++) sum += cosine_to_ref(r);
      ps = round_div(sum, ref_cnt);
    end
    if (batch_pts < NBATCH) begin
      sim_total += ps;
      valid_pts++;
      batch_pts++;
    end
    cur_len = 0;
  endtask

  // Applies one accepted word to the model and queues any report it causes.
  task automatic predict_word(logic [2:0] op, logic signed [15:0] val, logic last);
    report_t rep;
    longint avg, s;
    case (op)
      OP_REF_ELEM: begin
        if (ref_cnt < NREF) begin
          if (build_len < NDIM) ref_mem[ref_cnt][build_len] = val;
          if (build_len <= NDIM) build_len++;
          if (last) begin
            ref_len[ref_cnt] = build_len;
            ref_cnt++;
            build_len = 0;
          end
        end
      end
      OP_REF_EMPTY: begin
        if (ref_cnt < NREF) begin
          ref_len[ref_cnt] = 0;
          ref_cnt++;
          build_len = 0;
        end
      end
      OP_CUR_ELEM: begin
        if (cur_len < NDIM) cur_vec[cur_len] = val;
        if (cur_len <= NDIM) cur_len++;
        if (last) close_point();
      end
      OP_END_BATCH: begin
        rep = '{ST_OK, 16'd0, 1'b0, 16'd0, 17'd0};
        if (ref_cnt == 0) begin
          rep.status = ST_NO_REF;
        end else if (batch_pts == 0) begin
          rep.status = ST_BATCH_EMPTY;
        end else if (valid_pts == 0) begin
          rep.status = ST_NO_VALID;
        end else begin
          avg = round_div(sim_total, valid_pts);
          if (avg > SIM_ONE) avg = SIM_ONE;
          if (avg < -SIM_ONE) avg = -SIM_ONE;
          s = SCORE_ONE - 2 * avg;
          if (s < 0) s = 0;
          if (s > SCORE_ONE) s = SCORE_ONE;
          rep.score = s[15:0];
          rep.drifted = (s > thresh);
          rep.avg = avg[15:0];
          rep.count = valid_pts[16:0];
        end
        pending_reports.insert(pending_reports.size(), rep);
        sim_total = 0;
        valid_pts = 0;
        batch_pts = 0;
        cur_len = 0;
      end
      OP_CLEAR_REFS: begin
        ref_cnt = 0;
        build_len = 0;
      end
      OP_EMPTY_POINT: begin
        cur_len = 0;
        if (batch_pts < NBATCH) batch_pts++;
      end
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(logic [2:0] op, logic [15:0] val, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = val;
    s_tlast = last;
    do @(posedge clk); while (!s_tready);
    predict_word(op, val, last);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] element(int mode, int src, int i);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 128) - 64);
      2: return ref_mem[src][i];
      3: return -ref_mem[src][i];
      default: return 16'd0;
    endcase
  endfunction

  task automatic send_vector(logic [2:0] op, int len, int mode, int src);
    for (int i = 0; i < len; i++)
      send_word(op, element(mode, src, i), i == len - 1);
  endtask

  task automatic idle_bus();
    s_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    idle_bus();
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = 3'd0; pwdata = {16'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    thresh = value;
  endtask

  task automatic test_directed();
    send_word(OP_END_BATCH, 16'd0, 1'b1);        // no references yet
    send_word(OP_REF_ELEM, 16'h7FFF, 1'b0);
    send_word(OP_REF_ELEM, 16'h8000, 1'b1);
    send_word(OP_REF_EMPTY, 16'd0, 1'b1);
    send_word(OP_END_BATCH, 16'd0, 1'b0);        // batch empty
    send_word(OP_EMPTY_POINT, 16'd0, 1'b1);
    send_word(OP_END_BATCH, 16'd0, 1'b0);        // only empty points
    send_word(OP_CUR_ELEM, 16'h7FFF, 1'b0);
    send_word(OP_CUR_ELEM, 16'h8000, 1'b1);
    send_word(OP_CUR_ELEM, 16'h8000, 1'b0);
    send_word(OP_CUR_ELEM, 16'h7FFF, 1'b1);
    send_word(OP_CUR_ELEM, 16'd0, 1'b0);         // zero norm
    send_word(OP_CUR_ELEM, 16'd0, 1'b1);
    send_word(3'd6, 16'hFFFF, 1'b1);
    send_word(3'd7, 16'h1234, 1'b0);
    send_word(OP_CUR_ELEM, 16'd5, 1'b1);         // length mismatch
    send_word(OP_CUR_ELEM, 16'd9, 1'b0);
    send_word(OP_EMPTY_POINT, 16'd0, 1'b0);      // discards the partial vector
    send_word(OP_END_BATCH, 16'd0, 1'b1);
    send_word(OP_REF_ELEM, 16'd3, 1'b0);
    send_word(OP_REF_EMPTY, 16'd0, 1'b0);        // discards the partial reference
    send_word(OP_CLEAR_REFS, 16'd0, 1'b1);
  endtask

  task automatic test_threshold();
    write_threshold(16'd0);
    send_word(OP_REF_ELEM, 16'd100, 1'b1);
    send_word(OP_CUR_ELEM, 16'd100, 1'b1);       // score exactly zero
    send_word(OP_END_BATCH, 16'd0, 1'b0);
    send_word(OP_CUR_ELEM, 16'hFF00, 1'b1);      // score at full scale
    send_word(OP_END_BATCH, 16'd0, 1'b0);
    write_threshold(16'd32768);
    send_word(OP_CUR_ELEM, 16'hFF00, 1'b1);
    send_word(OP_END_BATCH, 16'd0, 1'b0);
    write_threshold(16'd3277);
  endtask

  task automatic test_long_vectors();
    send_word(OP_CLEAR_REFS, 16'd0, 1'b0);
    send_vector(OP_REF_ELEM, NDIM, 0, 0);
    send_vector(OP_REF_ELEM, NDIM + 2, 0, 0);
    send_vector(OP_CUR_ELEM, NDIM, 3, 0);
    send_vector(OP_CUR_ELEM, NDIM + 3, 1, 0);
    send_word(OP_END_BATCH, 16'd0, 1'b0);
  endtask

  task automatic test_store_full();
    send_word(OP_CLEAR_REFS, 16'd0, 1'b0);
    for (int r = 0; r < NREF + 3; r++) begin
      if (r % 9 == 4) send_word(OP_REF_EMPTY, 16'd0, 1'b0);
      else send_vector(OP_REF_ELEM, 2, 1, 0);
    end
    for (int p = 0; p < 4; p++) send_vector(OP_CUR_ELEM, 2, p == 0 ? 2 : 1, 1);
    send_word(OP_END_BATCH, 16'd0, 1'b0);
  endtask

  // Stalls the result side while short batches keep arriving against a single
  // reference, so reports pile up and the input is held off.
  task automatic test_output_stall();
    send_word(OP_CLEAR_REFS, 16'd0, 1'b0);
    send_vector(OP_REF_ELEM, 2, 1, 0);
    hold_len = 2000;
    hold_req++;
    for (int b = 0; b < 4; b++) begin
      send_vector(OP_CUR_ELEM, 2, 1, 0);
      send_word(OP_END_BATCH, 16'd0, 1'b0);
    end
  endtask

  task automatic test_random(int target);
    int nref, dim, npts, len, mode, src, phase;
    phase = 0;
    while (words_sent < target) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) send_vector(OP_REF_ELEM, $urandom_range(1, 3), 0, 0);
      if ($urandom_range(0, 2) != 0) send_word(OP_CLEAR_REFS, 16'($urandom), 1'($urandom));
      dim = $urandom_range(1, 8);
      nref = $urandom_range(0, 10) == 0 ? 0 : $urandom_range(1, 5);
      for (int r = 0; r < nref; r++) begin
        case ($urandom_range(0, 9))
          0: send_word(OP_REF_EMPTY, 16'($urandom), 1'($urandom));
          1: send_vector(OP_REF_ELEM, $urandom_range(1, 8), 0, 0);
          2: begin
            send_vector(OP_REF_ELEM, $urandom_range(1, 3), 0, 0);
            send_word(OP_REF_EMPTY, 16'd0, 1'($urandom));
          end
          default: send_vector(OP_REF_ELEM, dim, $urandom_range(0, 1), 0);
        endcase
      end
      npts = $urandom_range(1, 8);
      for (int p = 0; p < npts; p++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : dim;
        mode = $urandom_range(0, 4);
        src = $urandom_range(0, ref_cnt > 0 ? ref_cnt - 1 : 0);
        if ((mode == 2 || mode == 3) && (ref_cnt == 0 || ref_len[src] < len ||
                                         ref_len[src] > NDIM))
          mode = 0;
        case ($urandom_range(0, 11))
          0: send_word(OP_EMPTY_POINT, 16'($urandom), 1'($urandom));
          1: begin
            send_vector(OP_CUR_ELEM, $urandom_range(1, 3), 0, 0);
            send_word(OP_EMPTY_POINT, 16'd0, 1'($urandom));
          end
          2: send_word(3'($urandom_range(6, 7)), 16'($urandom), 1'($urandom));
          default: send_vector(OP_CUR_ELEM, len, mode, src);
        endcase
      end
      send_word(OP_END_BATCH, 16'($urandom), 1'($urandom));
      phase++;
      if (phase % 25 == 0) write_threshold(16'($urandom_range(0, 32768)));
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stalls plus a long hold-off on request.
  always @(negedge clk) begin : ready_driver
    static int gap = 0;
    static int held = 0;
    static int seen_req = 0;
    if (hold_req != seen_req) begin
      seen_req = hold_req;
      held = hold_len;
    end
    if (held > 0) begin
      held--;
      m_tready = 1'b0;
    end else if (gap > 0) begin
      gap--;
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
      gap = pick_gap();
    end
  end

  always @(posedge clk) begin : report_check
    report_t exp_rep;
    if (!rst && m_tvalid && m_tready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected report: status %0d data %h", m_tuser, m_tdata);
      end else begin
        exp_rep = pending_reports.pop_front();
        if (m_tuser !== exp_rep.status || m_tdata[15:0] !== exp_rep.score ||
            m_tdata[16] !== exp_rep.drifted || m_tdata[32:17] !== exp_rep.avg ||
            m_tdata[49:33] !== exp_rep.count || m_tdata[55:50] !== 6'd0) begin
          errors++;
          if (errors <= 10)
            $display("Report mismatch: expected status %0d score %0d drifted %0d",
                     exp_rep.status, exp_rep.score, exp_rep.drifted,
                     " avg %0d count %0d,", $signed(exp_rep.avg), exp_rep.count,
                     " got status %0d score %0d drifted %0d",
                     m_tuser, m_tdata[15:0], m_tdata[16],
                     " avg %0d count %0d", $signed(m_tdata[32:17]), m_tdata[49:33]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    thresh = THRESH_RESET;
    ref_cnt = 0; build_len = 0; cur_len = 0;
    sim_total = 0; valid_pts = 0; batch_pts = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_threshold();
    test_long_vectors();
    test_store_full();
    test_output_stall();
    test_random(1800);
    idle_bus();
    $display("Sent %0d words and checked %0d batch reports, covering every opcode,",
             words_sent, reports_seen);
    $display("a full reference store, oversized vectors and a long result stall.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
